### sv/idql_pkg.sv
`timescale 1ns / 1ps
package idql_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMD_W      = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_BACK   = 4'd0,
    CMD_ADD_FRONT  = 4'd1,
    CMD_GET        = 4'd2,
    CMD_POP_FIRST  = 4'd3,
    CMD_POP_LAST   = 4'd4,
    CMD_REMOVE     = 4'd5,
    CMD_PEEK_FIRST = 4'd6,
    CMD_PEEK_LAST  = 4'd7,
    CMD_SIZE       = 4'd8,
    CMD_CLEAR      = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_TAKE,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_FIRST,
    RD_LAST
  } rd_sel_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    capture;
    logic    exec;
    op_t     op;
    rd_sel_t rd_sel;
    logic    hit;
    status_t st;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             pos_ok;
  } dp_stat_t;

endpackage

### sv/idql_ctrl.sv
`timescale 1ns / 1ps
module idql_ctrl
  import idql_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl,
  output logic     busy,
  output logic     done
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
    end
  end

  always_comb begin
    state_next  = state;
    ctl.capture = 1'b0;
    ctl.exec    = 1'b0;
    ctl.op      = OP_NONE;
    ctl.rd_sel  = RD_POS;
    ctl.hit     = 1'b0;
    ctl.st      = ST_OK;
    busy        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        busy       = 1'b1;
        ctl.exec   = 1'b1;
        state_next = S_IDLE;
        // decode the captured command against the list state
        unique case (stat.cmd) inside
          CMD_ADD_BACK, CMD_ADD_FRONT: begin
            if (stat.full) begin
              ctl.st = ST_FULL;
            end else begin
              ctl.op = (stat.cmd == CMD_ADD_BACK) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end
          end
          CMD_GET, CMD_REMOVE: begin
            if (stat.empty) begin
              ctl.st = ST_EMPTY;
            end else if (!stat.pos_ok) begin
              ctl.st = ST_RANGE;
            end else begin
              ctl.hit = 1'b1;
              ctl.op  = (stat.cmd == CMD_REMOVE) ? OP_TAKE : OP_NONE;
            end
          end
          CMD_POP_FIRST, CMD_POP_LAST, CMD_PEEK_FIRST, CMD_PEEK_LAST: begin
            ctl.rd_sel = (stat.cmd == CMD_POP_FIRST || stat.cmd == CMD_PEEK_FIRST) ?
                         RD_FIRST : RD_LAST;
            if (stat.empty) begin
              ctl.st = ST_EMPTY;
            end else begin
              ctl.hit = 1'b1;
              ctl.op  = (stat.cmd == CMD_POP_FIRST || stat.cmd == CMD_POP_LAST) ?
                        OP_TAKE : OP_NONE;
            end
          end
          CMD_CLEAR: begin
            ctl.op = OP_CLEAR;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/idql_dp.sv
`timescale 1ns / 1ps
module idql_dp
  import idql_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dp_ctl_t               ctl,
  input  logic [CMD_W-1:0]      command,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [IDX_W-1:0]      position,
  output dp_stat_t              stat,
  output logic [VALUE_BITS-1:0] read_value,
  output logic                  found,
  output logic [CNT_W-1:0]      count,
  output logic [1:0]            status
);

  logic [CMD_W-1:0]      cmd_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [IDX_W-1:0]      pos_r;
  logic [CNT_W-1:0]      entry_count;
  logic [CNT_W-1:0]      entry_count_next;
  logic [VALUE_BITS-1:0] cells      [DEPTH];
  logic [VALUE_BITS-1:0] cells_next [DEPTH];
  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= command;
      val_r <= value;
      pos_r <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ctl.exec) begin
      entry_count <= entry_count_next;
    end
  end

  assign stat.cmd    = cmd_r;
  assign stat.empty  = (entry_count == '0);
  assign stat.full   = (entry_count == CNT_W'(DEPTH));
  assign stat.pos_ok = ({1'b0, pos_r} < entry_count);

  always_comb begin
    unique case (ctl.rd_sel)
      RD_FIRST: rd_addr = '0;
      RD_LAST:  rd_addr = IDX_W'(entry_count - CNT_W'(1));
      default:  rd_addr = pos_r;
    endcase
  end

  assign rd_data = cells[rd_addr];

  always_comb begin
    case (ctl.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: entry_count_next = entry_count + CNT_W'(1);
      OP_TAKE:                     entry_count_next = entry_count - CNT_W'(1);
      OP_CLEAR:                    entry_count_next = '0;
      default:                     entry_count_next = entry_count;
    endcase
  end

  // each cell picks its own value, a neighbour's or the new value
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_BITS-1:0] from_below;
    logic [VALUE_BITS-1:0] from_above;

    if (g == 0) begin : g_first
      assign from_below = val_r;
    end else begin : g_inner
      assign from_below = cells[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign from_above = cells[g];
    end else begin : g_upper
      assign from_above = cells[g+1];
    end

    always_comb begin
      cells_next[g] = cells[g];
      case (ctl.op)
        OP_PUSH_BACK: begin
          if (entry_count[IDX_W-1:0] == IDX_W'(g)) begin
            cells_next[g] = val_r;
          end
        end
        OP_PUSH_FRONT: cells_next[g] = from_below;
        OP_TAKE: begin
          if (IDX_W'(g) >= rd_addr) begin
            cells_next[g] = from_above;
          end
        end
        default: begin
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (ctl.exec) begin
        cells[g] <= cells_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      read_value <= ctl.hit ? rd_data : '0;
      found      <= ctl.hit;
      count      <= entry_count_next;
      status     <= ctl.st;
    end
  end

endmodule

### sv/indexed_deque_list_top.sv
`timescale 1ns / 1ps
// Bounded list of up to 16 32-bit values, packed from position zero. Raise
// start with command, value and position while busy is low; that transaction
// is taken on the clock edge. busy then stays high for one cycle while the
// list is updated, and in the cycle after, done is high for exactly one
// cycle with read_value, found, count and status valid. The receiver cannot
// stall: sample the result while done is high, as it is not held back.
// A new command may be given in the cycle that done is high, but not while
// busy is high, so commands are executed one at a time; the controller has a
// single execute state, in which all cells update in parallel. Status
// codes are ok, empty, full and index out of range; an add to a full list
// leaves the list untouched. Unused command codes behave as a size query.
// No clearing pass follows reset: the block accepts commands at once.
module indexed_deque_list_top
  import idql_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      command,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [IDX_W-1:0]      position,
  output logic                  done,
  output logic [VALUE_BITS-1:0] read_value,
  output logic                  found,
  output logic [CNT_W-1:0]      count,
  output logic [1:0]            status
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // controller: sequence the transaction and decide the list operation
  idql_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // datapath: hold the entries, shift them and register the result
  idql_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .command    (command),
    .value      (value),
    .position   (position),
    .stat       (stat),
    .read_value (read_value),
    .found      (found),
    .count      (count),
    .status     (status)
  );

  // an accepted transaction must occupy the execute cycle next
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not enter execute");

  // every result follows an execute cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without execute cycle");

  // a real entry is only reported with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == ST_OK))
    else $error("found set with error status");

  // the size never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= CNT_W'(DEPTH)))
    else $error("count beyond capacity");

endmodule
